// ===== sv/ffra_pkg.sv =====
`default_nettype none

package ffra_pkg;

  localparam int ADDR_W     = 32;
  localparam int HB_W       = 21;
  localparam int REQ_SIZE_W = 21;
  localparam int SIZE_W     = 22;   // request size after rounding up to 16
  localparam int LOW_W      = 22;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int STATUS_W   = 2;

  localparam int HB_MIN     = 64;
  localparam int HB_RESET   = 1048576;
  localparam int END_GUARD  = 47;   // 15 + 0x20
  localparam int LOW_GUARD  = 15;
  localparam int REC_COST   = 8;    // end limit moves by this per record

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_BASE  = 1'd0,
    REG_HEAP_BYTES = 1'd1
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // read address relative to the next walk index
  typedef enum logic [1:0] {
    RD_AT    = 2'd0,
    RD_BELOW = 2'd1,
    RD_ABOVE = 2'd2
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_SHIFT,
    S_INSERT,
    S_SEARCH,
    S_DSHIFT,
    S_DCOMMIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load_req;
    logic    walk_init;
    logic    walk_step;
    logic    shift_init;
    logic    shift_step;
    logic    ins_write;
    logic    del_step;
    logic    del_commit;
    logic    code_we;
    status_t code;
    rd_sel_t rd_sel;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic full;
    logic at_end;
    logic fit;
    logic match;
    logic shift_last;
    logic del_last;
    logic match_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/ffra_ram.sv =====
`default_nettype none

module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/ffra_ctrl.sv =====
`default_nettype none

module ffra_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ffra_pkg::sts_t sts,
  output ffra_pkg::cmd_t      cmd
);

  import ffra_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.code   = ST_OK;
    cmd.rd_sel = RD_AT;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_START;
        end
      end
      S_START: begin
        // index 0, read entry 0
        cmd.walk_init = 1'b1;
        if (sts.is_free) begin
          state_nxt = S_SEARCH;
        end else if (sts.full) begin
          cmd.code_we = 1'b1;
          cmd.code    = ST_FULL;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.fit) begin
          cmd.shift_init = 1'b1;
          cmd.rd_sel     = RD_BELOW;
          state_nxt      = sts.at_end ? S_INSERT : S_SHIFT;
        end else if (sts.at_end) begin
          cmd.code_we = 1'b1;
          cmd.code    = ST_NOFIT;
          state_nxt   = S_DONE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        cmd.rd_sel     = RD_BELOW;
        if (sts.shift_last) begin
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.ins_write = 1'b1;
        cmd.code_we   = 1'b1;
        cmd.code      = ST_OK;
        state_nxt     = S_DONE;
      end
      S_SEARCH: begin
        if (sts.at_end) begin
          cmd.code_we = 1'b1;
          cmd.code    = ST_NOTFOUND;
          state_nxt   = S_DONE;
        end else if (sts.match) begin
          cmd.rd_sel = RD_ABOVE;
          state_nxt  = sts.match_last ? S_DCOMMIT : S_DSHIFT;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_DSHIFT: begin
        cmd.del_step = 1'b1;
        cmd.rd_sel   = RD_ABOVE;
        if (sts.del_last) begin
          state_nxt = S_DCOMMIT;
        end
      end
      S_DCOMMIT: begin
        cmd.del_commit = 1'b1;
        cmd.code_we    = 1'b1;
        cmd.code       = ST_OK;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/ffra_dp.sv =====
`default_nettype none

module ffra_dp #(
  parameter int MAX_RECORDS = 64,
  parameter int OFFSET_BITS = 20
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_valid,
  input  wire logic [ffra_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [ffra_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic                                   in_req_type,
  input  wire logic [ffra_pkg::REQ_SIZE_W-1:0]        in_request_size,
  input  wire logic [ffra_pkg::ADDR_W-1:0]            in_release_address,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [ffra_pkg::STATUS_W-1:0]               out_status,
  output logic [ffra_pkg::ADDR_W-1:0]                 out_block_address,
  output logic signed [ffra_pkg::LOW_W-1:0]           out_low_water,
  input  wire ffra_pkg::cmd_t                         cmd,
  output ffra_pkg::sts_t                              sts
);

  import ffra_pkg::*;

  localparam int AW  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int IW  = AW + 1;
  localparam int LB  = OFFSET_BITS + 1;
  localparam int RW  = OFFSET_BITS + LB;
  localparam int SW  = (OFFSET_BITS + 2 > LOW_W) ? OFFSET_BITS + 2 : LOW_W;
  localparam int CW  = SW + 2;
  localparam logic signed [SW-1:0] HB_TOP = SW'(64'd1 << OFFSET_BITS);
  localparam logic signed [SW-1:0] HB_LO  = SW'(HB_MIN);
  localparam logic signed [SW-1:0] HB_RST =
    (SW'(HB_RESET) > HB_TOP) ? HB_TOP : SW'(HB_RESET);

  // control state
  logic [ADDR_W-1:0]    heap_base_r;
  logic [IW-1:0]        count_r;
  logic signed [SW-1:0] free_end_r, free_end_nxt;
  logic signed [SW-1:0] low_mark_r, low_mark_nxt;
  logic                 out_valid_r;

  // payload
  logic                 req_type_r;
  logic [SIZE_W-1:0]    size_r;
  logic [ADDR_W-1:0]    off_r;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [IW-1:0]        pos_r;
  logic [LB-1:0]        start_r, start_nxt;
  status_t              code_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [ADDR_W-1:0]    out_addr_r;
  logic [LOW_W-1:0]     out_low_r;

  // memory port
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [RW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [RW-1:0]        ram_rdata;
  logic [IW-1:0]        rd_idx;

  logic [OFFSET_BITS-1:0] rec_off;
  logic [LB-1:0]          rec_len;
  logic signed [CW-1:0]   fe_c, rec_off_c, gap_c, start_c, size_c;
  logic signed [SW-1:0]   hb_raw, hb_clamp, head;
  logic [SIZE_W-1:0]      size_round;
  logic                   hb_write;

  assign rec_off = ram_rdata[RW-1:LB];
  assign rec_len = ram_rdata[LB-1:0];

  ffra_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_RECORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // gap test: end of this gap clipped to the end limit, against the rounded size
  always_comb begin
    fe_c      = CW'(free_end_r);
    rec_off_c = CW'(rec_off);
    start_c   = CW'(start_r);
    size_c    = CW'(size_r);
    if (sts.at_end || rec_off_c > fe_c) begin
      gap_c = fe_c;
    end else begin
      gap_c = rec_off_c;
    end
  end

  always_comb begin
    sts.is_free    = req_type_r;
    sts.full       = (count_r == IW'(MAX_RECORDS));
    sts.at_end     = (idx_r == count_r);
    sts.fit        = (size_c <= gap_c - start_c);
    sts.match      = (ADDR_W'(rec_off) == off_r);
    sts.shift_last = (idx_r == pos_r + IW'(1));
    sts.del_last   = (idx_r + IW'(2) == count_r);
    sts.match_last = (idx_r + IW'(1) == count_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    idx_nxt   = idx_r;
    start_nxt = start_r;
    if (cmd.walk_init) begin
      idx_nxt   = '0;
      start_nxt = '0;
    end else if (cmd.walk_step) begin
      idx_nxt   = idx_r + IW'(1);
      start_nxt = LB'({1'b0, rec_off}) + rec_len;
    end else if (cmd.shift_init) begin
      idx_nxt = count_r;
    end else if (cmd.shift_step) begin
      idx_nxt = idx_r - IW'(1);
    end else if (cmd.del_step) begin
      idx_nxt = idx_r + IW'(1);
    end
    case (cmd.rd_sel)
      RD_BELOW: rd_idx = idx_nxt - IW'(1);
      RD_ABOVE: rd_idx = idx_nxt + IW'(1);
      default:  rd_idx = idx_nxt;
    endcase
    ram_raddr = rd_idx[AW-1:0];
  end

  always_comb begin
    ram_we    = cmd.shift_step || cmd.del_step || cmd.ins_write;
    ram_waddr = cmd.ins_write ? pos_r[AW-1:0] : idx_r[AW-1:0];
    ram_wdata = cmd.ins_write ? {start_c[OFFSET_BITS-1:0], size_c[LB-1:0]} : ram_rdata;
  end

  always_comb begin
    hb_write = cfg_valid && (cfg_index == REG_HEAP_BYTES);
    hb_raw = SW'(cfg_data[HB_W-1:0]);
    if (hb_raw < HB_LO) begin
      hb_clamp = HB_LO;
    end else if (hb_raw > HB_TOP) begin
      hb_clamp = HB_TOP;
    end else begin
      hb_clamp = hb_raw;
    end
    size_round = (SIZE_W'(in_request_size) + SIZE_W'(LOW_GUARD)) & ~SIZE_W'(LOW_GUARD);
    head = free_end_r - SW'(REC_COST) - SW'(start_r) - SW'(size_r);
    free_end_nxt = free_end_r;
    low_mark_nxt = low_mark_r;
    if (hb_write) begin
      free_end_nxt = hb_clamp - SW'(END_GUARD);
      low_mark_nxt = hb_clamp - SW'(LOW_GUARD);
    end else if (cmd.ins_write) begin
      free_end_nxt = free_end_r - SW'(REC_COST);
      if (head < low_mark_r) begin
        low_mark_nxt = head;
      end
    end else if (cmd.del_commit) begin
      free_end_nxt = free_end_r + SW'(REC_COST);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= '0;
      count_r     <= '0;
      free_end_r  <= HB_RST - SW'(END_GUARD);
      low_mark_r  <= HB_RST - SW'(LOW_GUARD);
      out_valid_r <= 1'b0;
    end else begin
      free_end_r <= free_end_nxt;
      low_mark_r <= low_mark_nxt;
      if (hb_write) begin
        count_r <= '0;
      end else if (cmd.ins_write) begin
        count_r <= count_r + IW'(1);
      end else if (cmd.del_commit) begin
        count_r <= count_r - IW'(1);
      end
      if (cfg_valid && cfg_index == REG_HEAP_BASE) begin
        heap_base_r <= cfg_data[ADDR_W-1:0];
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    start_r <= start_nxt;
    if (cmd.load_req) begin
      req_type_r <= in_req_type;
      size_r     <= size_round;
      off_r      <= in_release_address - heap_base_r;
    end
    if (cmd.shift_init) begin
      pos_r <= idx_r;
    end
    if (cmd.code_we) begin
      code_r <= cmd.code;
    end
    if (cmd.out_load) begin
      out_status_r <= code_r;
      out_low_r    <= low_mark_r[LOW_W-1:0];
      if (code_r == ST_OK && !req_type_r) begin
        out_addr_r <= heap_base_r + ADDR_W'(start_r);
      end else begin
        out_addr_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_low_water     = out_low_r;

endmodule

`default_nettype wire

// ===== sv/first_fit_region_allocator.sv =====
// First-fit region allocator. Records (offset, length) sit in one RAM sorted by
// offset. An allocate walks the gaps one record per cycle, then shifts the tail up
// one entry per cycle through the single RAM port pair and writes the new record;
// a free searches the same way and shifts the tail down. The RAM's one read and one
// write per cycle pace the walk and the shifts. A finished item waits until the
// output register is free.
// One item is worked at a time; the next is taken while a finished result waits in
// the output register.
// A heap_bytes write empties the table and restarts the end limit and low-water mark.
`default_nettype none

module first_fit_region_allocator #(
  parameter int MAX_RECORDS = 64,
  parameter int OFFSET_BITS = 20
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ffra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ffra_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_req_type,
  input  wire logic [ffra_pkg::REQ_SIZE_W-1:0]  in_request_size,
  input  wire logic [ffra_pkg::ADDR_W-1:0]      in_release_address,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [ffra_pkg::STATUS_W-1:0]         out_status,
  output logic [ffra_pkg::ADDR_W-1:0]           out_block_address,
  output logic signed [ffra_pkg::LOW_W-1:0]     out_low_water
);

  import ffra_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ffra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffra_dp #(
    .MAX_RECORDS (MAX_RECORDS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_req_type        (in_req_type),
    .in_request_size    (in_request_size),
    .in_release_address (in_release_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_block_address  (out_block_address),
    .out_low_water      (out_low_water),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

`default_nettype wire

// ===== sv/ffra_checker.sv =====
`default_nettype none

module ffra_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [ffra_pkg::STATUS_W-1:0]    out_status,
  input wire logic [ffra_pkg::ADDR_W-1:0]      out_block_address
);

  import ffra_pkg::*;

  logic [1:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items taken but whose result is not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 2'd1;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("item taken while another is in work");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3 && (out_valid -> pend_r != 2'd0))
    else $error("result count does not match items taken");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_block_address == '0)
    else $error("address given on a failed request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_block_address))
    else $error("stalled result changed");

endmodule

bind first_fit_region_allocator ffra_checker u_ffra_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_block_address (out_block_address)
);

`default_nettype wire

// ===== test/tb_first_fit_region_allocator.sv =====
`timescale 1ns / 1ps

module tb_first_fit_region_allocator;
  import ffra_pkg::*;

  localparam int MAX_RECORDS = 64;
  localparam int OFFSET_BITS = 20;
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE = 1'b1;
  // longest item is one pass over the table, with wide margin
  localparam int DRAIN_CYCLES = 2 * MAX_RECORDS + 16;
  localparam int CHOKE_CYCLES = 400;
  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] addr;
    logic [LOW_W-1:0]  low;
  } grant_t;

  // Tracks the heap table and the grants the block should return.
  class heap_tracker;
    logic [ADDR_W-1:0] base;
    logic [HB_W-1:0]   heap_size;
    int unsigned       rec_off [MAX_RECORDS];
    int unsigned       rec_len [MAX_RECORDS];
    int                count;
    longint            end_lim;
    longint            low_mark;
    grant_t            pending_grants [$];
    int errors, n_granted, n_nofit, n_full, n_freed, n_unmatched, n_writes;

    function new();
      base = '0;
      heap_size = HB_W'(HB_RESET);
      errors = 0;
      n_granted = 0;
      n_nofit = 0;
      n_full = 0;
      n_freed = 0;
      n_unmatched = 0;
      n_writes = 0;
      restart_heap();
    endfunction

    function void restart_heap();
      longint hb;
      hb = longint'(heap_size);
      if (hb < HB_MIN) hb = HB_MIN;
      if (hb > (longint'(1) << OFFSET_BITS)) hb = longint'(1) << OFFSET_BITS;
      count = 0;
      end_lim = hb - END_GUARD;
      low_mark = hb - LOW_GUARD;
    endfunction

    function void apply_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      n_writes++;
      case (idx)
        REG_HEAP_BASE: base = data;
        REG_HEAP_BYTES: begin
          heap_size = data[HB_W-1:0];
          restart_heap();
        end
        default: ;
      endcase
    endfunction

    function grant_t allocate(logic [REQ_SIZE_W-1:0] size);
      grant_t g;
      longint need, start, gap_end, head;
      int k, pos;
      bit found;
      g.status = ST_OK;
      g.addr = '0;
      need = (longint'(size) + 15) & ~longint'(15);
      start = 0;
      pos = count;
      found = 1'b0;
      if (count >= MAX_RECORDS) begin
        g.status = ST_FULL;
      end else begin
        // first fit: gap ends are clipped to the end limit
        for (k = 0; k <= count && !found; k++) begin
          gap_end = (k < count) ? longint'(rec_off[k]) : end_lim;
          if (gap_end > end_lim) gap_end = end_lim;
          if (need <= gap_end - start) begin
            found = 1'b1;
            pos = k;
          end else if (k < count) begin
            start = longint'(rec_off[k]) + longint'(rec_len[k]);
          end
        end
        if (!found) begin
          g.status = ST_NOFIT;
        end else begin
          for (k = count; k > pos; k--) begin
            rec_off[k] = rec_off[k-1];
            rec_len[k] = rec_len[k-1];
          end
          rec_off[pos] = start[31:0];
          rec_len[pos] = need[31:0];
          count++;
          end_lim -= REC_COST;
          head = end_lim - (start + need);
          if (head < low_mark) low_mark = head;
          g.addr = base + start[ADDR_W-1:0];
        end
      end
      g.low = low_mark[LOW_W-1:0];
      return g;
    endfunction

    function grant_t release_block(logic [ADDR_W-1:0] addr);
      grant_t g;
      logic [ADDR_W-1:0] off;
      int k, hit;
      off = addr - base;
      hit = -1;
      for (k = 0; k < count && hit < 0; k++)
        if (rec_off[k] == off) hit = k;
      g.addr = '0;
      if (hit < 0) begin
        g.status = ST_NOTFOUND;
      end else begin
        for (k = hit; k + 1 < count; k++) begin
          rec_off[k] = rec_off[k+1];
          rec_len[k] = rec_len[k+1];
        end
        count--;
        end_lim += REC_COST;
        g.status = ST_OK;
      end
      g.low = low_mark[LOW_W-1:0];
      return g;
    endfunction

    function void note_request(logic rt, logic [REQ_SIZE_W-1:0] size,
                               logic [ADDR_W-1:0] addr);
      grant_t g;
      if (rt == REQ_ALLOC) begin
        g = allocate(size);
        case (g.status)
          ST_OK:    n_granted++;
          ST_NOFIT: n_nofit++;
          default:  n_full++;
        endcase
      end else begin
        g = release_block(addr);
        if (g.status == ST_OK) n_freed++;
        else n_unmatched++;
      end
      pending_grants.push_back(g);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] addr,
                               logic [LOW_W-1:0] low);
      grant_t want;
      if (pending_grants.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: item with none expected: status %0d addr %h low_water %0d",
                   $time, status, addr, $signed(low));
        return;
      end
      want = pending_grants.pop_front();
      if (status !== want.status) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: status expected %0d, actual %0d", $time, want.status, status);
      end
      if (addr !== want.addr) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: block_address expected %h, actual %h", $time, want.addr, addr);
      end
      if (low !== want.low) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: low_water expected %0d, actual %0d", $time,
                   $signed(want.low), $signed(low));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = 1'b0;
  logic [REQ_SIZE_W-1:0] in_request_size = '0;
  logic [ADDR_W-1:0] in_release_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0] out_block_address;
  logic signed [LOW_W-1:0] out_low_water;

  heap_tracker book;
  bit pace_in = 1'b0;
  bit pace_out = 1'b0;
  int choke_len = 0;

  first_fit_region_allocator #(
    .MAX_RECORDS(MAX_RECORDS),
    .OFFSET_BITS(OFFSET_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_request_size(in_request_size),
    .in_release_address(in_release_address),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_block_address(out_block_address),
    .out_low_water(out_low_water)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    book.apply_reg(idx, data);
  endtask

  task automatic set_heap(input bit wr_base, input logic [CFG_DATA_W-1:0] base_val,
                          input bit wr_size, input logic [CFG_DATA_W-1:0] size_val);
    if (wr_base) write_reg(REG_HEAP_BASE, base_val);
    if (wr_size) write_reg(REG_HEAP_BYTES, size_val);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_request(input logic rt, input logic [REQ_SIZE_W-1:0] size,
                              input logic [ADDR_W-1:0] addr);
    int gap;
    gap = pace_in ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_request_size <= size;
    in_release_address <= addr;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    book.note_request(rt, size, addr);
  endtask

  task automatic wait_idle;
    in_valid <= 1'b0;
    while (book.pending_grants.size() != 0) @(posedge clk);
  endtask

  function automatic logic [REQ_SIZE_W-1:0] pick_size(int span);
    logic [REQ_SIZE_W-1:0] sz;
    case ($urandom_range(0, 11))
      0:       sz = '0;
      1:       sz = REQ_SIZE_W'($urandom);
      2:       sz = '1;
      3, 4:    sz = REQ_SIZE_W'($urandom_range(0, span));
      default: sz = REQ_SIZE_W'($urandom_range(0, 256));
    endcase
    return sz;
  endfunction

  // Mostly allocates and frees of live blocks; some frees aim at dead or random addresses.
  task automatic run_phase(input int n_items, input int alloc_pct, input int span,
                           input bit pace, input int choke_at);
    int i, roll;
    logic rt;
    logic [REQ_SIZE_W-1:0] sz;
    logic [ADDR_W-1:0] ra;
    pace_in = pace;
    pace_out = pace;
    for (i = 0; i < n_items; i++) begin
      if (i == choke_at) choke_len = CHOKE_CYCLES;
      sz = REQ_SIZE_W'($urandom);
      ra = $urandom;
      if ($urandom_range(0, 99) < alloc_pct) begin
        rt = REQ_ALLOC;
        sz = pick_size(span);
      end else begin
        rt = REQ_FREE;
        roll = $urandom_range(0, 9);
        if (book.count > 0 && roll < 7)
          ra = book.base + book.rec_off[$urandom_range(0, book.count - 1)];
        else if (roll < 9)
          ra = book.base + ($urandom_range(0, span) & ~32'hF);
      end
      send_request(rt, sz, ra);
    end
    wait_idle();
  endtask

  initial begin : result_sink
    int stall;
    forever begin
      if (choke_len > 0) begin
        stall = choke_len;
        choke_len = 0;
      end else begin
        stall = pace_out ? $urandom_range(0, 17) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1 || rst_n !== 1'b1) @(posedge clk);
      book.check_result(out_status, out_block_address, out_low_water);
    end
  end

  initial begin : stimulus
    book = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: size extremes, duplicate offsets, unmatched frees
    set_heap(1'b1, 32'h0000_1000, 1'b1, HB_RESET);
    send_request(REQ_ALLOC, 21'd0, $urandom);
    send_request(REQ_ALLOC, 21'd1, $urandom);
    send_request(REQ_ALLOC, 21'h1F_FFFF, $urandom);
    send_request(REQ_ALLOC, 21'd1048576, $urandom);
    send_request(REQ_ALLOC, 21'd1048496, $urandom);   // tight fit, negative headroom
    send_request(REQ_ALLOC, 21'd16, $urandom);
    send_request(REQ_FREE, REQ_SIZE_W'($urandom), 32'h0000_1000);
    send_request(REQ_FREE, REQ_SIZE_W'($urandom), 32'h0000_1000);
    send_request(REQ_FREE, REQ_SIZE_W'($urandom), 32'h0000_1000);
    send_request(REQ_FREE, REQ_SIZE_W'($urandom), 32'hFFFF_FFFF);
    send_request(REQ_FREE, REQ_SIZE_W'($urandom), 32'h0000_0000);
    send_request(REQ_FREE, REQ_SIZE_W'($urandom), 32'h0000_1010);
    wait_idle();

    // smallest heap: end limit goes negative, then even size 0 misses
    set_heap(1'b1, 32'hFFFF_FFF0, 1'b1, 32'd64);
    send_request(REQ_ALLOC, 21'd16, $urandom);
    send_request(REQ_ALLOC, 21'd0, $urandom);
    send_request(REQ_ALLOC, 21'd0, $urandom);
    send_request(REQ_ALLOC, 21'd0, $urandom);
    send_request(REQ_FREE, REQ_SIZE_W'($urandom), 32'hFFFF_FFF0);
    send_request(REQ_ALLOC, 21'd0, $urandom);
    wait_idle();

    set_heap(1'b1, $urandom & ~32'hF, 1'b1, HB_RESET);
    run_phase(110, 95, 4096, 1'b1, -1);                  // fills the table
    set_heap(1'b1, 32'hFFFF_FFF0, 1'b0, '0);             // rebase live records, wraps
    run_phase(100, 50, 8192, 1'b0, 20);
    set_heap(1'b1, $urandom, 1'b1, 32'hFFFF_FFFF);       // oversized heap clamps
    run_phase(100, 60, 1048576, 1'b1, -1);
    set_heap(1'b0, '0, 1'b1, 32'd4096);
    run_phase(100, 55, 512, 1'b1, -1);
    set_heap(1'b0, '0, 1'b1, 32'd63);                    // undersized heap clamps
    run_phase(30, 60, 32, 1'b1, -1);
    set_heap(1'b1, $urandom & ~32'hF, 1'b1, $urandom_range(HB_MIN, HB_RESET));
    run_phase(80, 65, 2048, 1'b0, -1);
    set_heap(1'b1, '0, 1'b1, 32'hFFE0_0000);             // masked to 0
    run_phase(20, 60, 64, 1'b1, -1);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Allocates: %0d granted, %0d with no fitting gap, %0d on a full table.",
             book.n_granted, book.n_nofit, book.n_full);
    $display("Frees: %0d matched, %0d unmatched; %0d register writes across heap sizes.",
             book.n_freed, book.n_unmatched, book.n_writes);
    if (book.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== first_fit_region_allocator.f =====
sv/ffra_pkg.sv
sv/ffra_ram.sv
sv/ffra_ctrl.sv
sv/ffra_dp.sv
sv/first_fit_region_allocator.sv
sv/ffra_checker.sv
test/tb_first_fit_region_allocator.sv
